>>> rtl/skit_pkg.sv
// Package for the sorted key index table: field widths, function and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package skit_pkg;

  localparam int TableDepthDefault = 256;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 31;
  localparam int OFS_W  = 31;
  localparam int LEN_W  = 16;
  localparam int RANK_W = 8;
  localparam int STAT_W = 3;
  localparam int HELD_W = 9;

  localparam int ENTRY_W  = KEY_W + OFS_W + LEN_W;
  localparam int IN_DW    = ((KEY_W + OFS_W + LEN_W + RANK_W + 7) / 8) * 8;
  localparam int OUT_DW   = ((KEY_W + OFS_W + LEN_W + HELD_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_FOUND   = 3'd1,
    ST_MISSING = 3'd2,
    ST_DUP     = 3'd3,
    ST_BAD     = 3'd4
  } status_e;

  // Which address the table read port takes this cycle.
  typedef enum logic [2:0] {
    RD_MID  = 3'd0,
    RD_LO   = 3'd1,
    RD_LAST = 3'd2,
    RD_PREV = 3'd3,
    RD_RANK = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic    latch;       // capture the input word, start a search
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    srch_step;   // narrow [lo, hi) with the key just read
    logic    wr_move;     // write read data one place up, step the pointer down
    logic    wr_put;      // write the new entry at lo, bump the count
    logic    res_load;
    status_e res_status;
    logic    res_entry;   // result carries the read entry, else zeros
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  srch_more;   // lo < hi
    logic  rank_ok;     // rank < count
    logic  hit;         // lo < count and stored key equals the key
    logic  full;
    logic  append;      // lo == count, nothing to move
    logic  move_last;   // pointer has reached lo
    logic  out_free;
  } stat_t;

endpackage

>>> rtl/skit_datapath.sv
// Datapath of the sorted key index table: entry memory, search bounds, shift
// pointer, entry count and the result and output registers. Uses skit_pkg.
`timescale 1ns / 1ps

module skit_datapath #(
  parameter int TABLE_DEPTH = skit_pkg::TableDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [skit_pkg::IN_DW-1:0] s_data_i,
  input  logic [skit_pkg::FUNC_W-1:0] s_func_i,
  input  skit_pkg::cmd_t             cmd_i,
  output skit_pkg::stat_t            stat_o,
  input  logic                       m_ready_i,
  output logic                       m_valid_o,
  output logic [skit_pkg::OUT_DW-1:0] m_data_o,
  output logic [skit_pkg::STAT_W-1:0] m_status_o
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > skit_pkg::RANK_W) ? CW : skit_pkg::RANK_W;
  localparam int KW   = skit_pkg::KEY_W;
  localparam int OW   = skit_pkg::OFS_W;
  localparam int LW   = skit_pkg::LEN_W;

  logic [skit_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [skit_pkg::ENTRY_W-1:0] rdata_q;

  logic [skit_pkg::FUNC_W-1:0] func_q;
  logic [KW-1:0]               key_q;
  logic [OW-1:0]               ofs_q;
  logic [LW-1:0]               len_q;
  logic [skit_pkg::RANK_W-1:0] rank_q;

  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, cnt_q, cnt_d, mid;
  logic [AW-1:0] ptr_q, ptr_d, rd_addr, wr_addr;
  logic [skit_pkg::ENTRY_W-1:0] wr_data;
  logic          wr_en;
  logic [KW-1:0] rd_key;

  logic [skit_pkg::STAT_W-1:0] res_status_q;
  logic [skit_pkg::ENTRY_W-1:0] res_entry_q;
  logic                         m_valid_q;
  logic [skit_pkg::OUT_DW-1:0]  m_data_q;
  logic [skit_pkg::STAT_W-1:0]  m_status_q;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_key = rdata_q[skit_pkg::ENTRY_W-1 -: KW];

  always_comb begin
    unique case (cmd_i.rd_sel)
      skit_pkg::RD_MID:  rd_addr = AW'(mid);
      skit_pkg::RD_LO:   rd_addr = AW'(lo_q);
      skit_pkg::RD_LAST: rd_addr = AW'(cnt_q - CW'(1));
      skit_pkg::RD_PREV: rd_addr = ptr_q - AW'(1);
      skit_pkg::RD_RANK: rd_addr = AW'(rank_q);
      default:           rd_addr = AW'(lo_q);
    endcase
  end

  assign wr_en   = cmd_i.wr_move | cmd_i.wr_put;
  assign wr_addr = cmd_i.wr_put ? AW'(lo_q) : ptr_q + AW'(1);
  assign wr_data = cmd_i.wr_put ? {key_q, ofs_q, len_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.latch) begin
      lo_d = '0;
      hi_d = cnt_q;
    end else if (cmd_i.srch_step) begin
      if (rd_key < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.rd_en && cmd_i.rd_sel == skit_pkg::RD_LAST) begin
      ptr_d = AW'(cnt_q - CW'(1));
    end else if (cmd_i.wr_move) begin
      ptr_d = ptr_q - AW'(1);
    end
    if (cmd_i.wr_put) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= '0;
      hi_q      <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= s_func_i;
      key_q  <= s_data_i[KW-1:0];
      ofs_q  <= s_data_i[KW +: OW];
      len_q  <= s_data_i[KW+OW +: LW];
      rank_q <= s_data_i[KW+OW+LW +: skit_pkg::RANK_W];
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_entry_q  <= cmd_i.res_entry ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      m_status_q <= res_status_q;
      m_data_q   <= skit_pkg::OUT_DW'({skit_pkg::HELD_W'(cnt_q),
                                       res_entry_q[LW-1:0],
                                       res_entry_q[LW +: OW],
                                       res_entry_q[LW+OW +: KW]});
    end
  end

  always_comb begin
    stat_o.func      = skit_pkg::func_e'(func_q);
    stat_o.srch_more = lo_q < hi_q;
    stat_o.rank_ok   = CMPW'(rank_q) < CMPW'(cnt_q);
    stat_o.hit       = (lo_q < cnt_q) && (rd_key == key_q);
    stat_o.full      = cnt_q == CW'(TABLE_DEPTH);
    stat_o.append    = lo_q == cnt_q;
    stat_o.move_last = ptr_q == AW'(lo_q);
    stat_o.out_free  = !m_valid_q || m_ready_i;
  end

  assign m_valid_o  = m_valid_q;
  assign m_data_o   = m_data_q;
  assign m_status_o = m_status_q;

endmodule

>>> rtl/skit_ctrl.sv
// Controller of the sorted key index table: one-hot state machine that steps the
// search, the shift and the result handoff. Uses skit_pkg.
`timescale 1ns / 1ps

module skit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  skit_pkg::stat_t stat_i,
  output skit_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_SRD  = 9'b000000100,
    S_SCMP = 9'b000001000,
    S_HCHK = 9'b000010000,
    S_MOVE = 9'b000100000,
    S_PUT  = 9'b001000000,
    S_RCAP = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = skit_pkg::RD_LO;
    cmd_o.res_status = skit_pkg::ST_BAD;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat_i.func == skit_pkg::FN_LOOKUP ||
                     stat_i.func == skit_pkg::FN_INSERT) begin
          state_d = S_SRD;
        end else if (stat_i.func == skit_pkg::FN_READ && stat_i.rank_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skit_pkg::RD_RANK;
          state_d      = S_RCAP;
        end else begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_SRD: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.srch_more) begin
          cmd_o.rd_sel = skit_pkg::RD_MID;
          state_d      = S_SCMP;
        end else begin
          state_d = S_HCHK;
        end
      end
      S_SCMP: begin
        cmd_o.srch_step = 1'b1;
        state_d         = S_SRD;
      end
      S_HCHK: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_DONE;
        if (stat_i.func == skit_pkg::FN_LOOKUP) begin
          cmd_o.res_status = stat_i.hit ? skit_pkg::ST_FOUND : skit_pkg::ST_MISSING;
          cmd_o.res_entry  = stat_i.hit;
        end else begin
          priority if (stat_i.hit) begin
            cmd_o.res_status = skit_pkg::ST_DUP;
          end else if (stat_i.full) begin
            cmd_o.res_status = skit_pkg::ST_BAD;
          end else if (stat_i.append) begin
            cmd_o.res_load = 1'b0;
            state_d        = S_PUT;
          end else begin
            cmd_o.res_load = 1'b0;
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_sel   = skit_pkg::RD_LAST;
            state_d        = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        cmd_o.wr_move = 1'b1;
        if (stat_i.move_last) begin
          state_d = S_PUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skit_pkg::RD_PREV;
        end
      end
      S_PUT: begin
        cmd_o.wr_put     = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = skit_pkg::ST_DONE;
        state_d          = S_DONE;
      end
      S_RCAP: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = skit_pkg::ST_DONE;
        cmd_o.res_entry  = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = state_q == S_IDLE;

endmodule

>>> rtl/sorted_key_index_table.sv
// Top level of the sorted key index table: a controller and a datapath joined by
// command and status structs. Uses skit_pkg, skit_ctrl and skit_datapath.
//
//   channel   direction  payload
//   s_axis    in         tuser: func; tdata: key, start_offset, record_length, rank
//   m_axis    out        tuser: status; tdata: entry_key, entry_start,
//                        entry_length, entries_held
//
// Words are handled one at a time. A lookup binary-searches the held entries; an
// insert does the same search, moves each entry from the last down to the insert
// position one place up and writes the new entry; a read fetches the entry at its
// rank. The search and the shift go through the entry memory, which has one read
// port and one write port. Reset clears the count, the search bounds, the shift
// pointer, the output valid and the control state only; the entry memory is never
// read below the count until written, so it needs no clearing. A stalled result
// waits in the output register while the table finishes the item; a new word is
// taken once that result has been loaded into the output register.
`timescale 1ns / 1ps

module sorted_key_index_table #(
  parameter int TABLE_DEPTH = skit_pkg::TableDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: key [30:0], start_offset [61:31], record_length [77:62], rank [85:78]
  input  logic [skit_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [skit_pkg::FUNC_W-1:0] s_axis_tuser_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: entry_key [30:0], entry_start [61:31], entry_length [77:62],
  //        entries_held [86:78]
  output logic [skit_pkg::OUT_DW-1:0] m_axis_tdata_o,
  // tuser: status [2:0]
  output logic [skit_pkg::STAT_W-1:0] m_axis_tuser_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i
);

  skit_pkg::cmd_t  cmd;
  skit_pkg::stat_t stat;

  // The controller decides each step from the datapath's status bits.
  skit_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The datapath owns the table memory, the search bounds and the output word.
  skit_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_data_i   (s_axis_tdata_i),
    .s_func_i   (s_axis_tuser_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_data_o   (m_axis_tdata_o),
    .m_status_o (m_axis_tuser_o)
  );

endmodule

>>> rtl/skit_checker.sv
// Port-level checks for the sorted key index table, bound to the top level.
// Uses skit_pkg.
`timescale 1ns / 1ps

module skit_checker #(
  parameter int TABLE_DEPTH = skit_pkg::TableDepthDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [skit_pkg::OUT_DW-1:0] m_axis_tdata_o,
  input logic [skit_pkg::STAT_W-1:0] m_axis_tuser_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i
);

  localparam int HELD_LSB = skit_pkg::KEY_W + skit_pkg::OFS_W + skit_pkg::LEN_W;

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // Only one item is in the table logic at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("word accepted while the previous one is still at work");

  // Status codes stay in range and the count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o <= skit_pkg::ST_BAD) &&
      (m_axis_tdata_o[HELD_LSB +: skit_pkg::HELD_W] <= skit_pkg::HELD_W'(TABLE_DEPTH)))
    else $error("status or entry count out of range");

  // Misses, rejections and bad requests carry no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == skit_pkg::ST_MISSING ||
                        m_axis_tuser_o == skit_pkg::ST_DUP ||
                        m_axis_tuser_o == skit_pkg::ST_BAD) |->
      m_axis_tdata_o[HELD_LSB-1:0] == '0)
    else $error("entry fields not zero on a result without an entry");

endmodule

bind sorted_key_index_table skit_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_skit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

>>> tb/tb_top.sv
// Self-checking testbench for sorted_key_index_table: stream stimulus, a scoreboard
// class that predicts every answer word, and random stalls on both channels.
// Depends on skit_pkg and the sorted_key_index_table RTL.
`timescale 1ns / 1ps

module tb_top;
  import skit_pkg::*;

  localparam int Depth      = TableDepthDefault;
  localparam int CycleLimit = 3_000_000;
  localparam int RandomWords = 1330;
  localparam int SettleCycles = 400;

  // One expected answer word, split into its fields.
  typedef struct packed {
    status_e     status;
    logic [30:0] key;
    logic [30:0] start;
    logic [15:0] length;
    logic [8:0]  held;
  } answer_t;

  // Tracks the sorted table on the side and queues the answer each accepted
  // command word must produce, then matches answer words against that queue.
  class key_table_checker;
    logic [30:0] keys   [Depth];
    logic [30:0] starts [Depth];
    logic [15:0] lengths[Depth];
    int          held;
    int          errors;
    answer_t     answers[$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function void note_command(func_e fn, logic [30:0] k, logic [30:0] so,
                               logic [15:0] rl, logic [7:0] rk);
      answer_t a;
      int      pos;
      bit      hit;
      a = '0;
      a.status = ST_BAD;
      // First position whose key is not below k; the table is sorted.
      pos = 0;
      while (pos < held && keys[pos] < k) pos++;
      hit = (pos < held) && (keys[pos] == k);
      case (fn)
        FN_LOOKUP: begin
          if (hit) begin
            a.status = ST_FOUND;
            a.key    = keys[pos];
            a.start  = starts[pos];
            a.length = lengths[pos];
          end else begin
            a.status = ST_MISSING;
          end
        end
        FN_INSERT: begin
          // A present key counts as duplicate even when the table is full.
          if (hit) begin
            a.status = ST_DUP;
          end else if (held < Depth) begin
            for (int j = held; j > pos; j--) begin
              keys[j]    = keys[j-1];
              starts[j]  = starts[j-1];
              lengths[j] = lengths[j-1];
            end
            keys[pos]    = k;
            starts[pos]  = so;
            lengths[pos] = rl;
            held++;
            a.status = ST_DONE;
          end
        end
        FN_READ: begin
          if (int'(rk) < held) begin
            a.status = ST_DONE;
            a.key    = keys[rk];
            a.start  = starts[rk];
            a.length = lengths[rk];
          end
        end
        default: ;
      endcase
      a.held = held[8:0];
      answers.push_back(a);
    endfunction

    task check_answer(logic [2:0] st, logic [30:0] k, logic [30:0] so,
                      logic [15:0] rl, logic [8:0] n);
      answer_t a;
      if (answers.size() == 0) begin
        report($sformatf("answer word with nothing expected, status %0d", st));
        return;
      end
      a = answers.pop_front();
      if (st !== a.status)
        report($sformatf("status %0d, expected %0d", st, a.status));
      if (k !== a.key)
        report($sformatf("entry_key %0h, expected %0h", k, a.key));
      if (so !== a.start)
        report($sformatf("entry_start %0h, expected %0h", so, a.start));
      if (rl !== a.length)
        report($sformatf("entry_length %0h, expected %0h", rl, a.length));
      if (n !== a.held)
        report($sformatf("entries_held %0d, expected %0d", n, a.held));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [OUT_DW-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;

  key_table_checker table_chk;
  int               cycle_count = 0;
  bit               quiet = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_key_index_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one command word, notes it once taken, then idles for a random gap.
  // Valid stays high across back-to-back words so it never drops and rises
  // within one time step.
  task automatic send_word(func_e fn, logic [30:0] k, logic [30:0] so,
                           logic [15:0] rl, logic [7:0] rk);
    int gap;
    s_tdata  <= {2'b00, rk, rl, so, k};
    s_tuser  <= fn;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    table_chk.note_command(fn, k, so, rl, rk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every expected answer has come back. It always
  // waits for the clock before it checks, so valid never drops and rises in one step.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (table_chk.answers.size() != 0);
  endtask

  // Answer words are checked at the edge that takes them.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      table_chk.check_answer(m_tuser, m_tdata[30:0], m_tdata[61:31], m_tdata[77:62],
                             m_tdata[86:78]);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** sorted_key_index_table: FAILED **");
      $finish;
    end
  end

  // Receiver: runs of ready, some of them long, broken by random stalls.
  initial begin
    int run;
    int gap;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          r;
    int          n;
    int          ins_pct;
    func_e       fn;
    logic [30:0] k;
    logic [7:0]  rk;

    table_chk = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: empty table, extremes, ends and middle of the order,
    // duplicates, hits and near misses, ranks at and past the count.
    send_word(FN_LOOKUP, 31'd0, 31'd0, 16'd0, 8'd0);
    send_word(FN_READ, 31'd0, 31'd0, 16'd0, 8'd0);
    send_word(FN_NONE, '1, '1, '1, '1);
    send_word(FN_INSERT, 31'd1000, '1, '1, 8'd0);
    send_word(FN_INSERT, 31'd0, 31'd0, 16'd0, 8'd0);
    send_word(FN_INSERT, '1, 31'h2AAA_AAAA, 16'h5555, '1);
    send_word(FN_INSERT, 31'd500, 31'h5555_5555, 16'hAAAA, 8'd3);
    send_word(FN_INSERT, 31'd1000, 31'd7, 16'd7, 8'd0);
    send_word(FN_INSERT, '1, 31'd9, 16'd9, 8'd0);
    send_word(FN_LOOKUP, 31'd1000, 31'd0, 16'd0, 8'd0);
    send_word(FN_LOOKUP, 31'd0, '1, '1, '1);
    send_word(FN_LOOKUP, '1, 31'd0, 16'd0, 8'd0);
    send_word(FN_LOOKUP, 31'd999, 31'd0, 16'd0, 8'd0);
    send_word(FN_LOOKUP, 31'h7FFF_FFFE, 31'd0, 16'd0, 8'd0);
    send_word(FN_READ, 31'd0, 31'd0, 16'd0, 8'd0);
    send_word(FN_READ, 31'd0, 31'd0, 16'd0, 8'd3);
    send_word(FN_READ, '1, '1, '1, 8'd4);
    send_word(FN_READ, 31'd0, 31'd0, 16'd0, '1);
    send_word(FN_NONE, 31'd500, 31'd0, 16'd0, 8'd0);
    send_word(FN_LOOKUP, 31'd500, 31'd0, 16'd0, 8'd0);
    wait_drained();

    // Random words. Inserts dominate until the table fills, then keep hitting
    // the full and duplicate paths. Keys are often taken from the table or
    // placed right beside a held key so that hits and near misses are common.
    for (int i = 0; i < RandomWords; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (i == 650) wait_drained();
      n = table_chk.held;
      ins_pct = (n < Depth) ? 55 : 30;
      r = $urandom_range(0, 99);
      if (r < ins_pct) fn = FN_INSERT;
      else if (r < ins_pct + 22) fn = FN_LOOKUP;
      else if (r < 96) fn = FN_READ;
      else fn = FN_NONE;

      k = 31'($urandom);
      r = $urandom_range(0, 99);
      if (n > 0 && r < 45)
        k = table_chk.keys[$urandom_range(0, n - 1)];
      else if (n > 0 && r < 55)
        k = table_chk.keys[$urandom_range(0, n - 1)] +
            ($urandom_range(0, 1) ? 31'd1 : 31'h7FFF_FFFF);
      else if (r < 60)
        k = $urandom_range(0, 1) ? 31'd0 : 31'h7FFF_FFFF;

      rk = 8'($urandom);
      r = $urandom_range(0, 99);
      if (n > 0 && r < 70) rk = 8'($urandom_range(0, n - 1));
      else if (r < 80) rk = n[7:0];

      send_word(fn, k, 31'($urandom), 16'($urandom), rk);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (table_chk.answers.size() != 0)
      table_chk.report($sformatf("%0d answers never arrived", table_chk.answers.size()));
    if (table_chk.errors == 0) begin
      $display("** sorted_key_index_table: PASSED **");
    end else begin
      $display("** sorted_key_index_table: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/skit_pkg.sv
rtl/skit_datapath.sv
rtl/skit_ctrl.sv
rtl/sorted_key_index_table.sv
rtl/skit_checker.sv
tb/tb_top.sv
